// ----- hw/rtl/saxs_pkg.sv -----
`default_nettype none
package saxs_pkg;

  localparam int ALPHABET_MAX       = 256;
  localparam int SAMPLE_WIDTH       = 16;
  localparam int MAX_SEGMENT_LENGTH = 256;
  localparam int MAX_SEGMENTS       = 16;

  localparam int BP_DEPTH  = ALPHABET_MAX - 1;
  localparam int BP_W      = 16;
  localparam int BP_IDX_W  = 8;
  localparam int SUM_W     = 24;
  localparam int CNT_W     = 8;
  localparam int SEG_W     = 4;
  localparam int SEGCNT_W  = 5;
  localparam int SYM_W     = 8;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int MEAN_W    = 17;
  localparam int DIV_STEPS = SUM_W;
  localparam int STEP_W    = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_VALUES_PER_SEGMENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_COUNT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CARDINALITY        = 2'd2;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef struct packed {
    logic                        command;
    logic [BP_IDX_W-1:0]         breakpoint_index;
    logic signed [BP_W-1:0]      breakpoint_value;
    logic signed [SAMPLE_WIDTH-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic [SEG_W-1:0] segment_index;
    logic             last_segment;
  } out_item_t;

  typedef struct packed {
    logic load_bp;
    logic add_sample;
    logic div_step;
    logic scan_issue;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic seg_close;
    logic div_last;
    logic scan_last;
  } dp_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_SCAN = 5'b00100,
    ST_TAIL = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/saxs_datapath.sv -----
`default_nettype none
module saxs_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [saxs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [saxs_pkg::CFG_W-1:0]        cfg_data,
  input  wire saxs_pkg::in_item_t                in_item,
  input  wire saxs_pkg::dp_cmd_t                 cmd,
  output saxs_pkg::dp_stat_t                     stat,
  output saxs_pkg::out_item_t                    out_item
);

  logic [saxs_pkg::CFG_W-1:0]     vps_r;
  logic [saxs_pkg::SEGCNT_W-1:0]  segcnt_r;
  logic [saxs_pkg::CFG_W-1:0]     card_r;

  logic [saxs_pkg::CFG_W-1:0]     n_eff;
  logic [saxs_pkg::SEGCNT_W-1:0]  segs_eff;
  logic [saxs_pkg::BP_IDX_W-1:0]  used_eff;

  logic signed [saxs_pkg::SUM_W-1:0] sum_r;
  logic signed [saxs_pkg::SUM_W-1:0] sum_nxt;
  logic [saxs_pkg::CNT_W-1:0]        cnt_r;
  logic [saxs_pkg::SEG_W-1:0]        seg_r;
  logic [saxs_pkg::SEG_W-1:0]        seg_idx_r;
  logic                              last_r;
  logic                              last_nxt;

  logic [saxs_pkg::SUM_W-1:0]     q_r;
  logic [saxs_pkg::CFG_W-1:0]     rem_r;
  logic                           neg_r;
  logic [saxs_pkg::STEP_W-1:0]    step_r;
  logic [saxs_pkg::CFG_W:0]       rem_sh;
  logic [saxs_pkg::CFG_W:0]       rem_diff;
  logic                           rem_ge;

  logic signed [saxs_pkg::MEAN_W-1:0] mean;
  logic [saxs_pkg::MEAN_W-1:0]        mag17;

  logic signed [saxs_pkg::BP_W-1:0]  bp_mem [saxs_pkg::BP_DEPTH];
  logic signed [saxs_pkg::BP_W-1:0]  rd_data_r;
  logic                              rd_pend_r;
  logic [saxs_pkg::BP_IDX_W-1:0]     k_r;
  logic [saxs_pkg::SYM_W-1:0]        sym_r;
  saxs_pkg::out_item_t               out_r;

  // register clamping
  always_comb begin
    if (vps_r == '0) begin
      n_eff = saxs_pkg::CFG_W'(1);
    end else if (vps_r > saxs_pkg::CFG_W'(saxs_pkg::MAX_SEGMENT_LENGTH)) begin
      n_eff = saxs_pkg::CFG_W'(saxs_pkg::MAX_SEGMENT_LENGTH);
    end else begin
      n_eff = vps_r;
    end
    if (segcnt_r == '0) begin
      segs_eff = saxs_pkg::SEGCNT_W'(1);
    end else if (segcnt_r > saxs_pkg::SEGCNT_W'(saxs_pkg::MAX_SEGMENTS)) begin
      segs_eff = saxs_pkg::SEGCNT_W'(saxs_pkg::MAX_SEGMENTS);
    end else begin
      segs_eff = segcnt_r;
    end
    if (card_r < saxs_pkg::CFG_W'(2)) begin
      used_eff = saxs_pkg::BP_IDX_W'(1);
    end else if (card_r > saxs_pkg::CFG_W'(saxs_pkg::ALPHABET_MAX)) begin
      used_eff = saxs_pkg::BP_IDX_W'(saxs_pkg::BP_DEPTH);
    end else begin
      used_eff = saxs_pkg::BP_IDX_W'(card_r - saxs_pkg::CFG_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vps_r    <= saxs_pkg::CFG_W'(16);
      segcnt_r <= saxs_pkg::SEGCNT_W'(16);
      card_r   <= saxs_pkg::CFG_W'(256);
    end else if (cfg_we) begin
      case (cfg_index)
        saxs_pkg::CFG_VALUES_PER_SEGMENT: vps_r    <= cfg_data;
        saxs_pkg::CFG_SEGMENT_COUNT:      segcnt_r <= cfg_data[saxs_pkg::SEGCNT_W-1:0];
        saxs_pkg::CFG_CARDINALITY:        card_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // accumulation
  assign sum_nxt = sum_r + saxs_pkg::SUM_W'(in_item.sample);
  assign stat.seg_close =
    ({1'b0, cnt_r} + saxs_pkg::CFG_W'(1)) >= n_eff;
  assign last_nxt =
    ({1'b0, seg_r} + saxs_pkg::SEGCNT_W'(1)) >= segs_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
      seg_r <= '0;
    end else if (cmd.add_sample) begin
      if (stat.seg_close) begin
        sum_r <= '0;
        cnt_r <= '0;
        seg_r <= last_nxt ? '0 : seg_r + saxs_pkg::SEG_W'(1);
      end else begin
        sum_r <= sum_nxt;
        cnt_r <= cnt_r + saxs_pkg::CNT_W'(1);
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  assign rem_sh   = {rem_r, q_r[saxs_pkg::SUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, n_eff};
  assign rem_ge   = rem_sh >= {1'b0, n_eff};
  assign stat.div_last = step_r == saxs_pkg::STEP_W'(saxs_pkg::DIV_STEPS - 1);

  always_ff @(posedge clk) begin
    if (cmd.add_sample && stat.seg_close) begin
      q_r       <= sum_nxt[saxs_pkg::SUM_W-1] ? saxs_pkg::SUM_W'(-sum_nxt)
                                              : saxs_pkg::SUM_W'(sum_nxt);
      neg_r     <= sum_nxt[saxs_pkg::SUM_W-1];
      rem_r     <= '0;
      step_r    <= '0;
      seg_idx_r <= seg_r;
      last_r    <= last_nxt;
    end else if (cmd.div_step) begin
      q_r    <= {q_r[saxs_pkg::SUM_W-2:0], rem_ge};
      rem_r  <= rem_ge ? rem_diff[saxs_pkg::CFG_W-1:0] : rem_sh[saxs_pkg::CFG_W-1:0];
      step_r <= step_r + saxs_pkg::STEP_W'(1);
    end
  end

  assign mag17 = {1'b0, q_r[saxs_pkg::MEAN_W-2:0]};
  assign mean  = neg_r ? -signed'(mag17) : signed'(mag17);

  // breakpoint table and scan
  always_ff @(posedge clk) begin
    if (cmd.load_bp &&
        in_item.breakpoint_index != saxs_pkg::BP_IDX_W'(saxs_pkg::BP_DEPTH)) begin
      bp_mem[in_item.breakpoint_index] <= in_item.breakpoint_value;
    end
    if (cmd.scan_issue) begin
      rd_data_r <= bp_mem[k_r];
    end
  end

  assign stat.scan_last = k_r == (used_eff - saxs_pkg::BP_IDX_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= cmd.scan_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_sample && stat.seg_close) begin
      k_r   <= '0;
      sym_r <= '0;
    end else begin
      if (cmd.scan_issue) begin
        k_r <= k_r + saxs_pkg::BP_IDX_W'(1);
      end
      if (rd_pend_r && (saxs_pkg::MEAN_W'(rd_data_r) < mean)) begin
        sym_r <= sym_r + saxs_pkg::SYM_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.symbol        <= sym_r;
      out_r.segment_index <= seg_idx_r;
      out_r.last_segment  <= last_r;
    end
  end

  assign out_item = out_r;

endmodule
`default_nettype wire

// ----- hw/rtl/saxs_ctrl.sv -----
`default_nettype none
module saxs_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  input  wire logic                   in_command,
  output logic                        in_stall,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  input  wire saxs_pkg::dp_stat_t     stat,
  output saxs_pkg::dp_cmd_t           cmd
);

  saxs_pkg::state_t state_r;
  saxs_pkg::state_t state_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             in_accept;
  logic             out_free;

  assign in_stall  = state_r != saxs_pkg::ST_IDLE;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt      = state_r;
    cmd.load_bp    = 1'b0;
    cmd.add_sample = 1'b0;
    cmd.div_step   = 1'b0;
    cmd.scan_issue = 1'b0;
    cmd.out_load   = 1'b0;
    case (state_r)
      saxs_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (in_command == saxs_pkg::CMD_SAMPLE) begin
            cmd.add_sample = 1'b1;
            if (stat.seg_close) begin
              state_nxt = saxs_pkg::ST_DIV;
            end
          end else begin
            cmd.load_bp = 1'b1;
          end
        end
      end
      saxs_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = saxs_pkg::ST_SCAN;
        end
      end
      saxs_pkg::ST_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (stat.scan_last) begin
          state_nxt = saxs_pkg::ST_TAIL;
        end
      end
      saxs_pkg::ST_TAIL: begin
        state_nxt = saxs_pkg::ST_DONE;
      end
      saxs_pkg::ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = saxs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = saxs_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= saxs_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_close_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_command == saxs_pkg::CMD_SAMPLE && stat.seg_close)
      |=> state_r == saxs_pkg::ST_DIV)
    else $error("closing sample did not start the divider");

  a_div_to_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == saxs_pkg::ST_DIV && stat.div_last) |=> state_r == saxs_pkg::ST_SCAN)
    else $error("divider did not hand over to the scan");

  a_tail_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == saxs_pkg::ST_TAIL |=> state_r == saxs_pkg::ST_DONE)
    else $error("scan tail did not finish");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten while stalled");

endmodule
`default_nettype wire

// ----- hw/rtl/sax_symbolizer_unit.sv -----
// SAX symbolizer. Each transaction on the input channel is either a breakpoint
// load or one Q4.12 sample. Loads and samples that do not end a segment leave
// the block idle, ready for the next transaction. The sample that ends a segment
// occupies the block for a bit-serial division over 24 quotient bits, then for a
// read-out of each breakpoint in use (cardinality - 1) from the table,
// then for a tail state and a done state. The result sits in an output
// register, so work continues while it waits to be taken; a further finished
// segment waits in the block until it is. Breakpoint entries must be loaded
// before a segment reads them.
`default_nettype none
module sax_symbolizer_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [saxs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [saxs_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire saxs_pkg::in_item_t             in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output saxs_pkg::out_item_t                 out_data
);

  saxs_pkg::dp_cmd_t  cmd;
  saxs_pkg::dp_stat_t stat;

  saxs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_data.command),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  saxs_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_item  (out_data)
  );

endmodule
`default_nettype wire
